>>> design/bsmt_pkg.sv
package bsmt_pkg;

    // Default sizing of the table
    localparam int ENTRIES_DEF   = 8;
    localparam int MAX_PAGES_DEF = 256;

    // Address split and fixed field widths
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int VPAGE_W    = ADDR_W - PAGE_SHIFT;
    localparam int OWNER_W    = 6;
    localparam int CMD_W      = 3;
    localparam int SEL_W      = 3;
    localparam int CNT_W      = 9;
    localparam int EOUT_W     = 3;
    localparam int PIDX_W     = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_MAP    = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_UNMAP  = 3'd4
    } cmd_t;

    // Verdict of the shared compare unit for one table entry
    typedef struct packed {
        logic               owner_eq;
        logic               in_range;
        logic [VPAGE_W-1:0] offset;
    } cmp_res_t;

endpackage

>>> design/backing_store_map_table.sv
// Channel   Ports                                             Handshake
// --------  ------------------------------------------------  -------------------------
// command   cmd owner vaddr vpage entry_sel page_count        start high, busy low
// result    found entry_out page_index                        done high for one cycle
//
// Free, map and unknown commands raise done in the cycle after acceptance; the next
// transaction can be taken once done has dropped.
// Allocate, lookup and unmap-by-owner walk the table through one compare unit, one
// entry per cycle from a registered read of the entry store: done follows the last
// entry walked, which is the last table entry unless allocate or lookup hits early.
// busy stays high until the strobe is gone.
// Reset clears every mapped flag at once; no clearing pass is needed.
// The receiver cannot stall: each result stays on the ports until the next command is accepted.
module backing_store_map_table #(
    parameter int ENTRIES   = bsmt_pkg::ENTRIES_DEF,
    parameter int MAX_PAGES = bsmt_pkg::MAX_PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bsmt_pkg::CMD_W-1:0]      cmd,
    input  logic [bsmt_pkg::OWNER_W-1:0]    owner,
    input  logic [bsmt_pkg::ADDR_W-1:0]     vaddr,
    input  logic [bsmt_pkg::VPAGE_W-1:0]    vpage,
    input  logic [bsmt_pkg::SEL_W-1:0]      entry_sel,
    input  logic [bsmt_pkg::CNT_W-1:0]      page_count,
    output logic                            done,
    output logic                            found,
    output logic [bsmt_pkg::EOUT_W-1:0]     entry_out,
    output logic [bsmt_pkg::PIDX_W-1:0]     page_index
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int PCW = $clog2(MAX_PAGES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    // Sequencer and mapped flags (control, cleared by reset)
    state_t                         state_reg, state_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [ENTRIES-1:0]             mapped_reg, mapped_next;

    // Captured command and result (payload)
    bsmt_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [bsmt_pkg::OWNER_W-1:0]   owner_reg, owner_next;
    logic [bsmt_pkg::VPAGE_W-1:0]   page_reg, page_next;
    logic                           found_reg, found_next;
    logic [bsmt_pkg::EOUT_W-1:0]    eout_reg, eout_next;
    logic [bsmt_pkg::PIDX_W-1:0]    pidx_reg, pidx_next;

    // Entry store: owner, start page and page count of each entry
    logic [bsmt_pkg::OWNER_W-1:0]   own_mem   [ENTRIES];
    logic [bsmt_pkg::VPAGE_W-1:0]   start_mem [ENTRIES];
    logic [PCW-1:0]                 pages_mem [ENTRIES];
    logic [bsmt_pkg::OWNER_W-1:0]   rd_owner_reg;
    logic [bsmt_pkg::VPAGE_W-1:0]   rd_start_reg;
    logic [PCW-1:0]                 rd_pages_reg;
    logic [IW-1:0]                  rd_addr;
    logic                           mem_we;

    logic                           accept;
    logic                           sel_ok;
    logic [IW-1:0]                  sel_idx;
    logic [PCW-1:0]                 cnt_sat;
    logic                           last;
    logic                           hit;
    bsmt_pkg::cmp_res_t             cmp;

    assign accept  = start && !busy;
    assign sel_ok  = int'(entry_sel) < ENTRIES;
    assign sel_idx = IW'(entry_sel);
    // Saturate the page count to the largest range an entry may cover
    assign cnt_sat = (int'(page_count) > MAX_PAGES) ? PCW'(MAX_PAGES) : PCW'(page_count);
    assign last    = (idx_reg == IW'(ENTRIES - 1));

    // Read one entry ahead so that the registered data lines up with idx_reg
    always_comb
    begin
        rd_addr = '0;
        if (state_reg == S_SCAN && !last)
        begin
            rd_addr = idx_reg + 1'b1;
        end
    end

    // Shared compare unit: owner match, range test and page offset
    bsmt_cmp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_cmp (
        .ent_owner (rd_owner_reg),
        .ent_start (rd_start_reg),
        .ent_pages (rd_pages_reg),
        .key_owner (owner_reg),
        .key_page  (page_reg),
        .res       (cmp)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        mapped_next = mapped_reg;
        cmd_next    = cmd_reg;
        owner_next  = owner_reg;
        page_next   = page_reg;
        found_next  = found_reg;
        eout_next   = eout_reg;
        pidx_next   = pidx_reg;
        mem_we      = 1'b0;
        hit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = bsmt_pkg::cmd_t'(cmd);
                    owner_next = owner;
                    page_next  = vaddr[bsmt_pkg::ADDR_W-1:bsmt_pkg::PAGE_SHIFT];
                    idx_next   = '0;
                    found_next = 1'b0;
                    eout_next  = '0;
                    pidx_next  = '0;
                    state_next = S_RESP;
                    case (bsmt_pkg::cmd_t'(cmd))
                        bsmt_pkg::CMD_ALLOC,
                        bsmt_pkg::CMD_LOOKUP,
                        bsmt_pkg::CMD_UNMAP:
                        begin
                            state_next = S_SCAN;
                        end
                        bsmt_pkg::CMD_FREE:
                        begin
                            // Dropping the flag is enough: an unmapped entry's data never affects a result
                            if (sel_ok)
                            begin
                                mapped_next[sel_idx] = 1'b0;
                                found_next           = 1'b1;
                                eout_next            = entry_sel;
                            end
                        end
                        bsmt_pkg::CMD_MAP:
                        begin
                            if (sel_ok)
                            begin
                                mem_we               = 1'b1;
                                mapped_next[sel_idx] = 1'b1;
                                found_next           = 1'b1;
                                eout_next            = entry_sel;
                            end
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                case (cmd_reg)
                    bsmt_pkg::CMD_ALLOC:
                    begin
                        hit = !mapped_reg[idx_reg];
                    end
                    bsmt_pkg::CMD_LOOKUP:
                    begin
                        hit = mapped_reg[idx_reg] && cmp.owner_eq && cmp.in_range;
                    end
                    bsmt_pkg::CMD_UNMAP:
                    begin
                        if (cmp.owner_eq)
                        begin
                            mapped_next[idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        hit = 1'b0;
                    end
                endcase

                if (hit)
                begin
                    found_next = 1'b1;
                    eout_next  = bsmt_pkg::EOUT_W'(idx_reg);
                    if (cmd_reg == bsmt_pkg::CMD_LOOKUP)
                    begin
                        pidx_next = cmp.offset[bsmt_pkg::PIDX_W-1:0];
                    end
                    state_next = S_RESP;
                end
                else if (last)
                begin
                    // Unmap-by-owner always reports found; a miss reports nothing found
                    found_next = (cmd_reg == bsmt_pkg::CMD_UNMAP);
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            mapped_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            mapped_reg <= mapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        owner_reg <= owner_next;
        page_reg  <= page_next;
        found_reg <= found_next;
        eout_reg  <= eout_next;
        pidx_reg  <= pidx_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            own_mem[sel_idx]   <= owner;
            start_mem[sel_idx] <= vpage;
            pages_mem[sel_idx] <= cnt_sat;
        end
        rd_owner_reg <= own_mem[rd_addr];
        rd_start_reg <= start_mem[rd_addr];
        rd_pages_reg <= pages_mem[rd_addr];
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RESP);
    assign found      = found_reg;
    assign entry_out  = eout_reg;
    assign page_index = pidx_reg;

    // An accepted transaction holds the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a transaction");

    // The done strobe lasts a single cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    // Unmap-by-owner always completes with found set and entry zero
    a_unmap_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_reg == bsmt_pkg::CMD_UNMAP) |-> (found && entry_out == '0))
        else $error("unmap-by-owner result malformed");

    // A map to a valid entry leaves that entry mapped
    a_map_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == bsmt_pkg::CMD_MAP && sel_ok) |=> mapped_reg[$past(sel_idx)])
        else $error("mapped flag not set after map");

endmodule

>>> design/bsmt_cmp.sv
module bsmt_cmp #(
    parameter int MAX_PAGES = bsmt_pkg::MAX_PAGES_DEF
) (
    input  logic [bsmt_pkg::OWNER_W-1:0]        ent_owner,
    input  logic [bsmt_pkg::VPAGE_W-1:0]        ent_start,
    input  logic [$clog2(MAX_PAGES+1)-1:0]      ent_pages,
    input  logic [bsmt_pkg::OWNER_W-1:0]        key_owner,
    input  logic [bsmt_pkg::VPAGE_W-1:0]        key_page,
    output bsmt_pkg::cmp_res_t                  res
);

    logic [bsmt_pkg::VPAGE_W:0] diff;

    // Borrow out of the subtract means the page lies below the start
    assign diff = {1'b0, key_page} - {1'b0, ent_start};

    always_comb
    begin
        res.owner_eq = (ent_owner == key_owner);
        res.in_range = !diff[bsmt_pkg::VPAGE_W]
                       && (diff[bsmt_pkg::VPAGE_W-1:0] < bsmt_pkg::VPAGE_W'(ent_pages));
        res.offset   = diff[bsmt_pkg::VPAGE_W-1:0];
    end

endmodule

>>> dv/tb.sv
module tb;

    localparam int ENTRIES   = bsmt_pkg::ENTRIES_DEF;
    localparam int MAX_PAGES = bsmt_pkg::MAX_PAGES_DEF;

    // Command codes the block does not decode; they must give a null reply
    localparam logic [bsmt_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [bsmt_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Number of random transactions after the directed part
    localparam int RANDOM_CMDS = 1075;
    // Give up after this many cycles with no transaction in either direction
    localparam int STALL_LIMIT = 2000;
    // Settle time at the end: worst-case table walk plus margin
    localparam int DRAIN_CYCLES = ENTRIES + 6;
    // Window of issued commands in which the driver never idles
    localparam int BURST_FIRST = 400;
    localparam int BURST_LAST  = 650;

    typedef struct packed {
        logic [bsmt_pkg::CMD_W-1:0]   cmd;
        logic [bsmt_pkg::OWNER_W-1:0] owner;
        logic [bsmt_pkg::ADDR_W-1:0]  vaddr;
        logic [bsmt_pkg::VPAGE_W-1:0] vpage;
        logic [bsmt_pkg::SEL_W-1:0]   sel;
        logic [bsmt_pkg::CNT_W-1:0]   cnt;
    } map_cmd_t;

    typedef struct packed {
        logic                         found;
        logic [bsmt_pkg::EOUT_W-1:0]  entry_out;
        logic [bsmt_pkg::PIDX_W-1:0]  page_index;
    } map_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          start      = 1'b0;
    logic [bsmt_pkg::CMD_W-1:0]    cmd        = '0;
    logic [bsmt_pkg::OWNER_W-1:0]  owner      = '0;
    logic [bsmt_pkg::ADDR_W-1:0]   vaddr      = '0;
    logic [bsmt_pkg::VPAGE_W-1:0]  vpage      = '0;
    logic [bsmt_pkg::SEL_W-1:0]    entry_sel  = '0;
    logic [bsmt_pkg::CNT_W-1:0]    page_count = '0;

    logic                          busy;
    logic                          done;
    logic                          found;
    logic [bsmt_pkg::EOUT_W-1:0]   entry_out;
    logic [bsmt_pkg::PIDX_W-1:0]   page_index;

    backing_store_map_table DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .owner      (owner),
        .vaddr      (vaddr),
        .vpage      (vpage),
        .entry_sel  (entry_sel),
        .page_count (page_count),
        .done       (done),
        .found      (found),
        .entry_out  (entry_out),
        .page_index (page_index)
    );

    always #6 clk = ~clk;

    // Commands waiting to be driven, and replies the table owes us
    map_cmd_t   cmd_backlog[$];
    map_reply_t owed_replies[$];

    int total_cmds;
    int accepted_cmds;
    int issued_cmds;
    int mismatch_count;
    int stall_cycles;

    map_cmd_t next_cmd;

    // Shadow of the table as the block should hold it
    logic                         map_valid [ENTRIES];
    logic [bsmt_pkg::OWNER_W-1:0] map_owner [ENTRIES];
    logic [bsmt_pkg::VPAGE_W-1:0] map_start [ENTRIES];
    logic [bsmt_pkg::CNT_W-1:0]   map_pages [ENTRIES];

    // What the stimulus generator last mapped into each slot; used only to aim
    // lookups at ranges that may still be live
    logic [bsmt_pkg::OWNER_W-1:0] aim_owner [ENTRIES];
    logic [bsmt_pkg::VPAGE_W-1:0] aim_start [ENTRIES];
    logic [bsmt_pkg::CNT_W-1:0]   aim_pages [ENTRIES];

    function automatic map_cmd_t pack_cmd(input logic [bsmt_pkg::CMD_W-1:0] c,
                                          input logic [bsmt_pkg::OWNER_W-1:0] o,
                                          input logic [bsmt_pkg::ADDR_W-1:0] a,
                                          input logic [bsmt_pkg::VPAGE_W-1:0] vp,
                                          input logic [bsmt_pkg::SEL_W-1:0] s,
                                          input logic [bsmt_pkg::CNT_W-1:0] n);
        map_cmd_t m;
        m.cmd   = c;
        m.owner = o;
        m.vaddr = a;
        m.vpage = vp;
        m.sel   = s;
        m.cnt   = n;
        return m;
    endfunction

    // Apply one command to the shadow table and return the reply it must give.
    function automatic map_reply_t map_table_apply(input map_cmd_t c);
        map_reply_t                   r;
        logic [bsmt_pkg::VPAGE_W-1:0] pg;
        logic [bsmt_pkg::VPAGE_W-1:0] ofs;
        r  = '0;
        pg = c.vaddr[bsmt_pkg::ADDR_W-1:bsmt_pkg::PAGE_SHIFT];
        case (c.cmd)
            bsmt_pkg::CMD_ALLOC:
            begin
                for (int k = 0; k < ENTRIES; k++)
                begin
                    if (!r.found && !map_valid[k])
                    begin
                        r.found     = 1'b1;
                        r.entry_out = bsmt_pkg::EOUT_W'(k);
                    end
                end
            end
            bsmt_pkg::CMD_FREE:
            begin
                if (c.sel < ENTRIES)
                begin
                    map_valid[c.sel] = 1'b0;
                    map_owner[c.sel] = '0;
                    map_start[c.sel] = '0;
                    map_pages[c.sel] = '0;
                    r.found          = 1'b1;
                    r.entry_out      = c.sel;
                end
            end
            bsmt_pkg::CMD_MAP:
            begin
                if (c.sel < ENTRIES)
                begin
                    map_valid[c.sel] = 1'b1;
                    map_owner[c.sel] = c.owner;
                    map_start[c.sel] = c.vpage;
                    map_pages[c.sel] = (c.cnt > MAX_PAGES) ?
                                       bsmt_pkg::CNT_W'(MAX_PAGES) : c.cnt;
                    r.found          = 1'b1;
                    r.entry_out      = c.sel;
                end
            end
            bsmt_pkg::CMD_LOOKUP:
            begin
                // End of range is exclusive and there is no wrap past the top page
                for (int k = 0; k < ENTRIES; k++)
                begin
                    ofs = pg - map_start[k];
                    if (!r.found && map_valid[k] && map_owner[k] == c.owner &&
                        pg >= map_start[k] && ofs < map_pages[k])
                    begin
                        r.found      = 1'b1;
                        r.entry_out  = bsmt_pkg::EOUT_W'(k);
                        r.page_index = ofs[bsmt_pkg::PIDX_W-1:0];
                    end
                end
            end
            bsmt_pkg::CMD_UNMAP:
            begin
                // Start page survives; flag, owner and count go
                for (int k = 0; k < ENTRIES; k++)
                begin
                    if (map_owner[k] == c.owner)
                    begin
                        map_valid[k] = 1'b0;
                        map_owner[k] = '0;
                        map_pages[k] = '0;
                    end
                end
                r.found = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Stimulus: a directed opening, then weighted random traffic.
    initial
    begin
        int                           roll;
        int                           k;
        map_cmd_t                     it;
        logic [bsmt_pkg::VPAGE_W-1:0] pg;

        for (k = 0; k < ENTRIES; k++)
        begin
            aim_owner[k] = '0;
            aim_start[k] = '0;
            aim_pages[k] = '0;
        end

        // Empty table: allocate hands out entry 0, lookup finds nothing
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_ALLOC, '0, '0, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0));
        // Fill every entry: top-of-space range with an oversized count,
        // zero-page entry, overlapping ranges of one owner, single page, etc.
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, '1, '1, 20'hFFFF0, 3'd0, '1));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, '0, '0, '0, 3'd1, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, 6'd5, '0, 20'h12345, 3'd2, 9'd256));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, 6'd5, '0, 20'h12340, 3'd3, 9'd8));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, 6'h2A, '0, 20'h00100, 3'd4, 9'd1));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, 6'h15, '0, 20'h80000, 3'd5, 9'd257));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, 6'd5, '0, 20'h12345, 3'd6, 9'd3));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_MAP, '1, '0, '0, 3'd7, 9'd16));
        // Table full
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_ALLOC, '1, '1, '1, '1, '1));
        // Last page of the space, then a low page below that range's start
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, '1, 32'hFFFF_FFFF, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, '1, 32'h0000_5123, '0, '0, '0));
        // Zero-page entry never matches
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, '0, 32'h0000_0FFF, '0, '0, '0));
        // Lowest of several overlapping matches wins
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'd5, 32'h1234_7ABC, '0, '0, '0));
        // Exclusive end: one page hits, the next misses
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'h2A, 32'h0010_0000, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'h2A, 32'h0010_1000, '0, '0, '0));
        // Saturated count: offset 255 hits, 256 misses
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'h15, 32'h800F_F000, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'h15, 32'h8010_0000, '0, '0, '0));
        // Free one entry, reallocate it, then drop a whole owner
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_FREE, '0, '0, '0, 3'd2, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_ALLOC, '0, '0, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_UNMAP, 6'd5, '0, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_LOOKUP, 6'd5, 32'h1234_6000, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_ALLOC, '0, '0, '0, '0, '0));
        // Undecoded commands with busy fields, then an unmap of owner 0 and a free of entry 7
        cmd_backlog.push_back(pack_cmd(CMD_SPARE_LO, '1, '1, '1, '1, '1));
        cmd_backlog.push_back(pack_cmd(CMD_SPARE_HI, '1, '1, '1, '1, '1));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_UNMAP, '0, '0, '0, '0, '0));
        cmd_backlog.push_back(pack_cmd(bsmt_pkg::CMD_FREE, '1, '1, '1, 3'd7, '1));

        // Random part: mostly maps and aimed lookups over a few owners so that
        // ranges overlap and hit; the rest allocates, frees, unmaps and undecoded codes.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            roll     = $urandom_range(0, 99);
            it.owner = bsmt_pkg::OWNER_W'($urandom);
            it.vaddr = $urandom;
            it.vpage = bsmt_pkg::VPAGE_W'($urandom);
            it.sel   = bsmt_pkg::SEL_W'($urandom);
            it.cnt   = bsmt_pkg::CNT_W'($urandom);
            if (roll < 12)
                it.cmd = bsmt_pkg::CMD_ALLOC;
            else if (roll < 21)
                it.cmd = bsmt_pkg::CMD_FREE;
            else if (roll < 47)
            begin
                it.cmd = bsmt_pkg::CMD_MAP;
                if ($urandom_range(0, 3) != 0)
                    it.owner = bsmt_pkg::OWNER_W'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0)
                    it.vpage = bsmt_pkg::VPAGE_W'(32'h000F_FFFF - $urandom_range(0, 300));
                if ($urandom_range(0, 9) != 0)
                    it.cnt = bsmt_pkg::CNT_W'($urandom_range(0, MAX_PAGES));
                aim_owner[it.sel] = it.owner;
                aim_start[it.sel] = it.vpage;
                aim_pages[it.sel] = (it.cnt > MAX_PAGES) ?
                                    bsmt_pkg::CNT_W'(MAX_PAGES) : it.cnt;
            end
            else if (roll < 84)
            begin
                it.cmd = bsmt_pkg::CMD_LOOKUP;
                if ($urandom_range(0, 3) != 0)
                begin
                    // Aim inside a recent range, up to one page past its end
                    k        = $urandom_range(0, ENTRIES - 1);
                    it.owner = aim_owner[k];
                    pg       = bsmt_pkg::VPAGE_W'(aim_start[k] +
                                                  $urandom_range(0, aim_pages[k]));
                    it.vaddr = {pg, it.vaddr[bsmt_pkg::PAGE_SHIFT-1:0]};
                end
            end
            else if (roll < 95)
            begin
                it.cmd = bsmt_pkg::CMD_UNMAP;
                if ($urandom_range(0, 3) != 0)
                    it.owner = bsmt_pkg::OWNER_W'($urandom_range(0, 3));
            end
            else
                it.cmd = bsmt_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            cmd_backlog.push_back(it);
        end
        total_cmds = cmd_backlog.size();

        // Hold reset, then release it at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to go in and every reply to come back
        while (accepted_cmds < total_cmds || owed_replies.size() != 0)
            @(posedge clk);
        // Let any stray strobe show up before deciding
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Driver: present the next command once the slot is free. A command is
    // taken at an edge with start high and busy low; while busy, hold it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            cmd         <= '0;
            owner       <= '0;
            vaddr       <= '0;
            vpage       <= '0;
            entry_sel   <= '0;
            page_count  <= '0;
            issued_cmds <= 0;
        end
        else if (!start || !busy)
        begin
            // Idle at random, except through one long burst window
            if (cmd_backlog.size() != 0 &&
                ((issued_cmds >= BURST_FIRST && issued_cmds < BURST_LAST) ||
                 $urandom_range(0, 99) >= 37))
            begin
                next_cmd    = cmd_backlog.pop_front();
                cmd         <= next_cmd.cmd;
                owner       <= next_cmd.owner;
                vaddr       <= next_cmd.vaddr;
                vpage       <= next_cmd.vpage;
                entry_sel   <= next_cmd.sel;
                page_count  <= next_cmd.cnt;
                start       <= 1'b1;
                issued_cmds <= issued_cmds + 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each reply strobe against the oldest owed reply, then
    // predict the reply for any command taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                map_valid[k] = 1'b0;
                map_owner[k] = '0;
                map_start[k] = '0;
                map_pages[k] = '0;
            end
            owed_replies.delete();
            accepted_cmds  <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("reply strobe with no command outstanding");
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (entry_out !== want.entry_out)
                    begin
                        $error("entry_out: expected %0d, got %0d",
                               want.entry_out, entry_out);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (page_index !== want.page_index)
                    begin
                        $error("page_index: expected %0d, got %0d",
                               want.page_index, page_index);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                owed_replies.push_back(map_table_apply(pack_cmd(cmd, owner, vaddr, vpage,
                                                                entry_sel, page_count)));
                accepted_cmds <= accepted_cmds + 1;
            end
        end
    end

    // Watchdog: count cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
